// ===== design/ldfs_pkg.sv =====
// shared types and constants for the led driver frame serializer
`timescale 1ns / 1ps

package ldfs_pkg;

    // line symbol codes
    localparam logic [1:0] SYM_ZERO = 2'd0;
    localparam logic [1:0] SYM_ONE  = 2'd1;
    localparam logic [1:0] SYM_GAP  = 2'd2;

    // configuration register indexes
    localparam logic CFG_WIDE_SAMPLES = 1'b0;
    localparam logic CFG_GRAY_CLOCK   = 1'b1;

    // default group size
    localparam int CHANNELS_PER_LED_DEFAULT = 3;

    // word field widths
    localparam int VALUE_W    = 16;
    localparam int LEN_W      = 10;
    localparam int CLK_SEL_W  = 2;
    localparam int BITS_W     = 12;
    localparam int POS_W      = 2;
    localparam int CFG_DATA_W = 2;

    // descriptor queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    // serializer step numbering: header bits, header gap, value bits, tail gap
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] STEP_HDR_LAST   = 6'd35;
    localparam logic [STEP_W-1:0] STEP_HDR_GAP    = 6'd36;
    localparam logic [STEP_W-1:0] STEP_VALUE_LAST = 6'd48;
    localparam logic [STEP_W-1:0] STEP_VALUE_FIRST = 6'd37;
    localparam logic [STEP_W-1:0] STEP_TAIL_GAP   = 6'd49;

    // one classified word waiting for the serializer
    typedef struct packed {
        logic                 hdr_en;
        logic [CLK_SEL_W-1:0] clk_sel;
        logic [LEN_W-1:0]     chain_len;
        logic [BITS_W-1:0]    bits;
        logic                 gap_after;
    } desc_t;

endpackage

// ===== design/ldfs_front.sv =====
// front end: accepts words, holds configuration, tracks channel position
`timescale 1ns / 1ps

module ldfs_front
    import ldfs_pkg::*;
#(
    parameter int CHANNELS_PER_LED = CHANNELS_PER_LED_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [VALUE_W-1:0]    channel_value,
    input  logic                  frame_start,
    input  logic [LEN_W-1:0]      chain_length,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  q_full,
    output logic                  q_write,
    output desc_t                 q_desc
);

    logic                 wide_samples_reg;
    logic [CLK_SEL_W-1:0] gray_clock_select_reg;
    logic [POS_W-1:0]     position_reg;
    logic [POS_W-1:0]     position_next;
    logic [POS_W-1:0]     pos_base;
    logic [POS_W:0]       pos_inc;
    logic                 gap;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_samples_reg      <= 1'b0;
            gray_clock_select_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WIDE_SAMPLES: wide_samples_reg      <= cfg_data[0];
                CFG_GRAY_CLOCK:   gray_clock_select_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // channel position within the led group
    always_comb
    begin
        pos_base      = frame_start ? '0 : position_reg;
        pos_inc       = {1'b0, pos_base} + {{POS_W{1'b0}}, 1'b1};
        gap           = (pos_inc >= (POS_W+1)'(CHANNELS_PER_LED));
        position_next = gap ? '0 : pos_inc[POS_W-1:0];
    end

    assign q_write = push && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            position_reg <= '0;
        else if (q_write)
            position_reg <= position_next;
    end

    // classify the word into a descriptor
    always_comb
    begin
        q_desc.hdr_en    = frame_start;
        q_desc.clk_sel   = gray_clock_select_reg;
        q_desc.chain_len = chain_length;
        q_desc.bits      = wide_samples_reg ? channel_value[15:4]
                                            : {channel_value[7:0], 4'h0};
        q_desc.gap_after = gap;
    end

endmodule

// ===== design/ldfs_queue.sv =====
// short descriptor queue between front and back
`timescale 1ns / 1ps

module ldfs_queue
    import ldfs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr,
    input  desc_t wr_desc,
    input  logic  rd,
    output desc_t rd_desc,
    output logic  full,
    output logic  empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    desc_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_desc = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_desc;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== design/ldfs_back.sv =====
// back end: steps a descriptor one symbol per clock, unless the output waits for pop
`timescale 1ns / 1ps

module ldfs_back
    import ldfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  desc_t      q_desc,
    output logic       q_read,
    input  logic       pop,
    output logic       empty,
    output logic [1:0] symbol,
    output logic       run_end
);

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    desc_t             desc_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [1:0]        symbol_reg;
    logic [1:0]        symbol_next;
    logic              run_end_reg;
    logic              run_end_next;

    logic [35:0]       header;
    logic [STEP_W-1:0] hdr_idx;
    logic [STEP_W-1:0] val_diff;
    logic [STEP_W-1:0] last_step;
    logic              advance;
    logic              at_last;

    // header and current symbol
    always_comb
    begin
        header    = {12'hFFF, 2'b00, desc_reg.clk_sel, 8'h00, 2'b00, desc_reg.chain_len};
        hdr_idx   = STEP_HDR_LAST - step_reg;
        val_diff  = STEP_VALUE_LAST - step_reg;
        last_step = desc_reg.gap_after ? STEP_TAIL_GAP : STEP_VALUE_LAST;
        at_last   = (step_reg == last_step);
        priority if (step_reg <= STEP_HDR_LAST)
            symbol_next = header[hdr_idx] ? SYM_ONE : SYM_ZERO;
        else if (step_reg == STEP_HDR_GAP)
            symbol_next = SYM_GAP;
        else if (step_reg <= STEP_VALUE_LAST)
            symbol_next = desc_reg.bits[val_diff[3:0]] ? SYM_ONE : SYM_ZERO;
        else
            symbol_next = SYM_GAP;
        run_end_next = at_last;
    end

    // step control and descriptor loading
    always_comb
    begin
        advance   = busy_reg && (!out_valid_reg || pop);
        q_read    = 1'b0;
        busy_next = busy_reg;
        step_next = step_reg;
        if (advance && !at_last)
            step_next = step_reg + 1'b1;
        else if (!busy_reg || advance)
        begin
            q_read    = !q_empty;
            busy_next = !q_empty;
            step_next = q_desc.hdr_en ? '0 : STEP_VALUE_FIRST;
        end
    end

    // output register valid
    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_read)
            desc_reg <= q_desc;
        if (advance)
        begin
            symbol_reg  <= symbol_next;
            run_end_reg <= run_end_next;
        end
    end

    assign empty   = !out_valid_reg;
    assign symbol  = symbol_reg;
    assign run_end = run_end_reg;

endmodule

// ===== design/led_driver_frame_serializer.sv =====
// top level of the single-wire led driver frame serializer
`timescale 1ns / 1ps

// Takes one colour channel value per word and produces line symbols (zero bit,
// one bit, gap) for a single-wire LED driver chain, one symbol per clock. A word
// with frame_start set is preceded by the 36-bit header and a gap; every value
// goes out as 12 bits MSB first, and a gap follows each group of
// CHANNELS_PER_LED channels. A plain word thus makes 12 or 13 symbols, a
// frame-start word 49 (50 with one channel per LED); the serializer in the back end
// emits one symbol per clock while the result side pops every cycle. A
// two-entry descriptor queue lets the front take the next word while the back
// is still sending, and the result register lets a finished symbol wait for pop.

module led_driver_frame_serializer
    import ldfs_pkg::*;
#(
    parameter int CHANNELS_PER_LED = CHANNELS_PER_LED_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [VALUE_W-1:0]    channel_value,
    input  logic                  frame_start,
    input  logic [LEN_W-1:0]      chain_length,
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            symbol,
    output logic                  run_end,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic  q_write;
    logic  q_read;
    logic  q_empty;
    desc_t wr_desc;
    desc_t rd_desc;

    // word intake and classification
    ldfs_front #(
        .CHANNELS_PER_LED(CHANNELS_PER_LED)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .channel_value (channel_value),
        .frame_start   (frame_start),
        .chain_length  (chain_length),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_full        (full),
        .q_write       (q_write),
        .q_desc        (wr_desc)
    );

    // descriptor queue
    ldfs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_write),
        .wr_desc (wr_desc),
        .rd      (q_read),
        .rd_desc (rd_desc),
        .full    (full),
        .empty   (q_empty)
    );

    // symbol serializer
    ldfs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_desc  (rd_desc),
        .q_read  (q_read),
        .pop     (pop),
        .empty   (empty),
        .symbol  (symbol),
        .run_end (run_end)
    );

endmodule

// ===== tb/led_driver_frame_serializer_tb.sv =====
// testbench for the led driver frame serializer: queued driver, checking monitor, predictor
`timescale 1ns / 1ps

module led_driver_frame_serializer_tb;
    import ldfs_pkg::*;

    localparam int GROUP_SIZE     = CHANNELS_PER_LED_DEFAULT;
    localparam int HEADER_LEN     = 36;
    localparam int STALL_LIMIT    = 2000;
    localparam int WORDS_PER_PASS = 48;
    localparam int RANDOM_PASSES  = 6;

    // one input word as queued for the driver
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               fs;
        logic [LEN_W-1:0]   len;
    } led_word_t;

    // one line symbol as it should leave the block
    typedef struct packed {
        logic [1:0] sym;
        logic       last;
    } line_symbol_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [VALUE_W-1:0]    channel_value = '0;
    logic                  frame_start = 1'b0;
    logic [LEN_W-1:0]      chain_length = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [1:0]            symbol;
    logic                  run_end;
    logic                  cfg_write = 1'b0;
    logic                  cfg_index = CFG_WIDE_SAMPLES;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    led_word_t    pending_words[$];
    line_symbol_t expected_symbols[$];
    int           error_count = 0;
    int           stall_cycles = 0;
    int           sender_idle_pct = 24;
    int           receiver_idle_pct = 65;

    // mirrored block state
    logic               wide_mode = 1'b0;
    logic [1:0]         clock_sel = 2'd0;
    logic [POS_W-1:0]   group_pos = '0;

    led_driver_frame_serializer #(
        .CHANNELS_PER_LED(GROUP_SIZE)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .channel_value(channel_value),
        .frame_start  (frame_start),
        .chain_length (chain_length),
        .empty        (empty),
        .pop          (pop),
        .symbol       (symbol),
        .run_end      (run_end),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // expected symbols for one accepted word
    task automatic serialize_word(input logic [VALUE_W-1:0] value, input logic fs,
                                  input logic [LEN_W-1:0] len);
        logic [HEADER_LEN-1:0] header;
        logic [BITS_W-1:0]     bits;
        logic                  gap_after;
        int                    next_pos;
        line_symbol_t          entry;
        begin
            if (fs)
            begin
                header = {12'hFFF, 2'b00, clock_sel, 8'h00, 2'b00, len};
                for (int i = HEADER_LEN - 1; i >= 0; i--)
                begin
                    entry.sym  = header[i] ? SYM_ONE : SYM_ZERO;
                    entry.last = 1'b0;
                    expected_symbols.push_back(entry);
                end
                entry.sym  = SYM_GAP;
                entry.last = 1'b0;
                expected_symbols.push_back(entry);
                group_pos = '0;
            end
            bits = wide_mode ? value[15:4] : {value[7:0], 4'h0};
            next_pos = int'(group_pos) + 1;
            gap_after = (next_pos >= GROUP_SIZE);
            for (int i = BITS_W - 1; i >= 0; i--)
            begin
                entry.sym  = bits[i] ? SYM_ONE : SYM_ZERO;
                entry.last = (i == 0) && !gap_after;
                expected_symbols.push_back(entry);
            end
            if (gap_after)
            begin
                entry.sym  = SYM_GAP;
                entry.last = 1'b1;
                expected_symbols.push_back(entry);
                group_pos = '0;
            end
            else
            begin
                group_pos = next_pos[POS_W-1:0];
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            error_count++;
        end
    endtask

    task automatic queue_word(input logic [VALUE_W-1:0] value, input logic fs,
                              input logic [LEN_W-1:0] len);
        led_word_t w;
        begin
            w.value = value;
            w.fs    = fs;
            w.len   = len;
            pending_words.push_back(w);
        end
    endtask

    // hold the sender until every expected symbol is out
    task automatic wait_drained;
        begin
            while (pending_words.size() != 0 || push || expected_symbols.size() != 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
        end
    endtask

    task automatic write_register(input logic index, input logic [CFG_DATA_W-1:0] data);
        begin
            @(posedge clk);
            cfg_write <= 1'b1;
            cfg_index <= index;
            cfg_data  <= data;
            @(posedge clk);
            cfg_write <= 1'b0;
            if (index == CFG_WIDE_SAMPLES)
                wide_mode = data[0];
            else
                clock_sel = data;
        end
    endtask

    task automatic set_config(input logic wide, input logic [1:0] sel);
        begin
            wait_drained();
            write_register(CFG_WIDE_SAMPLES, {1'b0, wide});
            write_register(CFG_GRAY_CLOCK, sel);
        end
    endtask

    // driver: offers queued words, predicts on acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
                serialize_word(channel_value, frame_start, chain_length);
            if (!push || !full)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    led_word_t w;
                    w = pending_words.pop_front();
                    channel_value <= w.value;
                    frame_start   <= w.fs;
                    chain_length  <= w.len;
                    push          <= 1'b1;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each popped symbol with the oldest expectation
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_symbols.size() == 0)
                begin
                    report_mismatch("unexpected word, symbol", symbol, -1);
                end
                else
                begin
                    line_symbol_t want;
                    want = expected_symbols.pop_front();
                    if (symbol !== want.sym)
                        report_mismatch("symbol", symbol, want.sym);
                    if (run_end !== want.last)
                        report_mismatch("run_end", run_end, want.last);
                end
            end
            pop <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // stimulus
    initial
    begin
        int         words;
        int         frame_len;
        logic       pass_wide[RANDOM_PASSES];
        logic [1:0] pass_sel[RANDOM_PASSES];

        pass_wide = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        pass_sel  = '{2'd3, 2'd0, 2'd2, 2'd1, 2'd3, 2'd0};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // narrow samples: extremes, upper byte ignored, restart mid-group
        set_config(1'b0, 2'd0);
        queue_word(16'h0000, 1'b1, 10'd0);
        queue_word(16'h00FF, 1'b0, 10'd0);
        queue_word(16'hFF00, 1'b0, 10'h3FF);
        queue_word(16'h00A5, 1'b0, 10'd0);
        queue_word(16'hFFFF, 1'b1, 10'h3FF);
        queue_word(16'h0055, 1'b0, 10'd0);
        queue_word(16'h12AA, 1'b0, 10'd0);

        // wide samples, clock field set to 3
        set_config(1'b1, 2'd3);
        queue_word(16'hFFFF, 1'b1, 10'h2AA);
        queue_word(16'h000F, 1'b0, 10'd0);
        queue_word(16'h8000, 1'b0, 10'd0);
        queue_word(16'h7FF0, 1'b1, 10'h155);
        queue_word(16'h1234, 1'b0, 10'd0);

        // back-to-back frame starts
        set_config(1'b0, 2'd1);
        queue_word(16'h0080, 1'b1, 10'd5);
        queue_word(16'h0001, 1'b0, 10'd0);
        queue_word(16'h007F, 1'b1, 10'd3);
        set_config(1'b1, 2'd2);
        queue_word(16'hABCD, 1'b1, 10'd1);
        queue_word(16'h5432, 1'b1, 10'd512);

        // random frames, idling pattern changes every two passes
        for (int p = 0; p < RANDOM_PASSES; p++)
        begin
            set_config(pass_wide[p], pass_sel[p]);
            if (p < 2)
            begin
                sender_idle_pct   = 24;
                receiver_idle_pct = 65;
            end
            else if (p < 4)
            begin
                sender_idle_pct   = 65;
                receiver_idle_pct = 24;
            end
            else
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            words = 0;
            while (words < WORDS_PER_PASS)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // stray word outside a fresh frame
                    queue_word(16'($urandom), 1'b0, 10'($urandom));
                    words++;
                end
                else
                begin
                    frame_len = GROUP_SIZE * $urandom_range(1, 4);
                    if ($urandom_range(0, 3) == 0)
                        frame_len = frame_len - $urandom_range(1, GROUP_SIZE - 1);
                    queue_word(16'($urandom), 1'b1, 10'($urandom));
                    for (int i = 1; i < frame_len; i++)
                        queue_word(16'($urandom), 1'b0, 10'($urandom));
                    words += frame_len;
                end
                // in the second pass the sender holds off until the block has drained
                if (p == 1 && words >= WORDS_PER_PASS / 2 && words < WORDS_PER_PASS / 2 + 13)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
